// ----- design/iosf_pkg.sv -----
// iosf_pkg: shared widths, types and helpers of the imu offset/spike filter
// no dependencies; used by every file in design/
`default_nettype none

package iosf_pkg;

    localparam int AXES      = 6;
    localparam int RAW_W     = 16;
    localparam int VAL_W     = 17;
    localparam int SUM_W     = 33;
    localparam int QUO_W     = 32;
    localparam int CNT_W     = 16;
    localparam int ONE_G_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;
    localparam int DIV_STEPS = QUO_W;
    localparam int Z_LANE    = 2;
    localparam int ACCEL_LANES = 3;

    typedef logic signed [VAL_W-1:0] t_s17;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_TH  = 2'd0,
        CFG_GYRO_TH   = 2'd1,
        CFG_CALIB_CNT = 2'd2,
        CFG_ONE_G     = 2'd3
    } t_cfg_idx;

    // per-item controls broadcast to all lanes
    typedef struct packed {
        logic capture;
        logic calc_cur;
        logic calc_cmp;
        logic upd_last;
        logic accum;
        logic div_load;
        logic div_step;
        logic div_apply;
    } t_lane_ctrl;

    // clamp a 34-bit signed value to the 17-bit signed range
    function automatic t_s17 sat17(input logic signed [33:0] v);
        t_s17 res;
        if ((&v[33:VAL_W-1]) || !(|v[33:VAL_W-1])) begin
            res = v[VAL_W-1:0];
        end else if (v[33]) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- design/iosf_if.sv -----
// iosf_if: valid/ready channel interfaces for input, result and config words
// depends on iosf_pkg
`default_nettype none

interface iosf_in_if;
    logic valid;
    logic ready;
    logic req_type;
    logic signed [iosf_pkg::RAW_W-1:0] raw_accel_x;
    logic signed [iosf_pkg::RAW_W-1:0] raw_accel_y;
    logic signed [iosf_pkg::RAW_W-1:0] raw_accel_z;
    logic signed [iosf_pkg::RAW_W-1:0] raw_gyro_x;
    logic signed [iosf_pkg::RAW_W-1:0] raw_gyro_y;
    logic signed [iosf_pkg::RAW_W-1:0] raw_gyro_z;

    modport source (
        output valid, req_type, raw_accel_x, raw_accel_y, raw_accel_z,
               raw_gyro_x, raw_gyro_y, raw_gyro_z,
        input  ready
    );
    modport sink (
        input  valid, req_type, raw_accel_x, raw_accel_y, raw_accel_z,
               raw_gyro_x, raw_gyro_y, raw_gyro_z,
        output ready
    );
endinterface

interface iosf_out_if;
    logic valid;
    logic ready;
    logic signed [iosf_pkg::VAL_W-1:0] accel_x_out;
    logic signed [iosf_pkg::VAL_W-1:0] accel_y_out;
    logic signed [iosf_pkg::VAL_W-1:0] accel_z_out;
    logic signed [iosf_pkg::VAL_W-1:0] gyro_x_out;
    logic signed [iosf_pkg::VAL_W-1:0] gyro_y_out;
    logic signed [iosf_pkg::VAL_W-1:0] gyro_z_out;
    logic spike_held;
    logic calib_done;

    modport source (
        output valid, accel_x_out, accel_y_out, accel_z_out,
               gyro_x_out, gyro_y_out, gyro_z_out, spike_held, calib_done,
        input  ready
    );
    modport sink (
        input  valid, accel_x_out, accel_y_out, accel_z_out,
               gyro_x_out, gyro_y_out, gyro_z_out, spike_held, calib_done,
        output ready
    );
endinterface

interface iosf_cfg_if;
    logic valid;
    logic ready;
    logic [iosf_pkg::CFG_IDX_W-1:0] index;
    logic [iosf_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/iosf_lane.sv -----
// iosf_lane: one axis lane - offset correction, step compare, calibration sum
// and a bit-serial divider for the offset average; depends on iosf_pkg
`default_nettype none

module iosf_lane (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire iosf_pkg::t_lane_ctrl           i_ctrl,
    input  wire logic signed [iosf_pkg::RAW_W-1:0] i_raw,
    input  wire logic [iosf_pkg::VAL_W-1:0]     i_thresh,
    input  wire logic [iosf_pkg::CNT_W-1:0]     i_div_cnt,
    input  wire logic [iosf_pkg::ONE_G_W-1:0]   i_one_g,
    output logic                                o_over,
    output iosf_pkg::t_s17                      o_cur,
    output iosf_pkg::t_s17                      o_last
);

    logic signed [iosf_pkg::RAW_W-1:0] r_raw;
    iosf_pkg::t_s17                    r_cur;
    iosf_pkg::t_s17                    r_last;
    iosf_pkg::t_s17                    r_offset;
    logic signed [iosf_pkg::SUM_W-1:0] r_sum;
    logic                              r_over;
    logic                              r_neg;
    logic [iosf_pkg::CNT_W-1:0]        r_rem;
    logic [iosf_pkg::QUO_W-1:0]        r_quo;

    logic signed [iosf_pkg::VAL_W:0]   w_corr;
    logic signed [iosf_pkg::VAL_W:0]   w_diff;
    logic [iosf_pkg::VAL_W:0]          w_adiff;
    logic signed [iosf_pkg::SUM_W-1:0] n_sum;
    logic [iosf_pkg::SUM_W-1:0]        w_sum_mag;
    logic [iosf_pkg::CNT_W:0]          w_trial;
    logic                              w_ge;
    logic [iosf_pkg::CNT_W:0]          w_trial_sub;
    logic signed [33:0]                w_avg;
    logic signed [33:0]                w_avg_g;

    always_comb begin
        w_corr    = {{2{r_raw[iosf_pkg::RAW_W-1]}}, r_raw} - {r_offset[iosf_pkg::VAL_W-1], r_offset};
        w_diff    = {r_cur[iosf_pkg::VAL_W-1], r_cur} - {r_last[iosf_pkg::VAL_W-1], r_last};
        w_adiff   = w_diff[iosf_pkg::VAL_W] ? -w_diff : w_diff;
        n_sum     = r_sum + {{(iosf_pkg::SUM_W-iosf_pkg::RAW_W){r_raw[iosf_pkg::RAW_W-1]}}, r_raw};
        w_sum_mag = n_sum[iosf_pkg::SUM_W-1] ? -n_sum : n_sum;
        // restoring divide, one quotient bit per step
        w_trial     = {r_rem, r_quo[iosf_pkg::QUO_W-1]};
        w_ge        = w_trial >= {1'b0, i_div_cnt};
        w_trial_sub = w_trial - {1'b0, i_div_cnt};
        w_avg       = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
        w_avg_g     = w_avg - $signed({19'd0, i_one_g});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_raw <= i_raw;
        end
        if (i_ctrl.calc_cur) begin
            r_cur <= iosf_pkg::sat17({{16{w_corr[iosf_pkg::VAL_W]}}, w_corr});
        end
        if (i_ctrl.calc_cmp) begin
            r_over <= w_adiff > {1'b0, i_thresh};
        end
        if (i_ctrl.div_load) begin
            r_neg <= n_sum[iosf_pkg::SUM_W-1];
            r_quo <= w_sum_mag[iosf_pkg::QUO_W-1:0];
            r_rem <= '0;
        end else if (i_ctrl.div_step) begin
            r_quo <= {r_quo[iosf_pkg::QUO_W-2:0], w_ge};
            r_rem <= w_ge ? w_trial_sub[iosf_pkg::CNT_W-1:0] : w_trial[iosf_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_offset <= '0;
            r_sum    <= '0;
        end else begin
            if (i_ctrl.upd_last) begin
                r_last <= r_cur;
            end
            if (i_ctrl.accum) begin
                r_sum <= i_ctrl.div_load ? '0 : n_sum;
            end
            if (i_ctrl.div_apply) begin
                r_offset <= iosf_pkg::sat17(w_avg_g);
            end
        end
    end

    assign o_over = r_over;
    assign o_cur  = r_cur;
    assign o_last = r_last;

endmodule

`default_nettype wire

// ----- design/iosf_merge.sv -----
// iosf_merge: combines lane compare flags into the spike decision and holds
// the result word register; depends on iosf_pkg and iosf_if
`default_nettype none

module iosf_merge (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_load,
    input  wire                               i_first_pending,
    input  wire                               i_calib_done,
    input  wire logic [iosf_pkg::AXES-1:0]    i_over,
    input  wire iosf_pkg::t_s17               i_cur  [iosf_pkg::AXES],
    input  wire iosf_pkg::t_s17               i_last [iosf_pkg::AXES],
    output logic                              o_spike,
    output logic                              o_free,
    iosf_out_if.source                        o_out
);

    logic           r_valid;
    logic           r_spike;
    logic           r_done;
    iosf_pkg::t_s17 r_val [iosf_pkg::AXES];

    assign o_spike = !i_first_pending && (|i_over);
    assign o_free  = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < iosf_pkg::AXES; i++) begin
                r_val[i] <= o_spike ? i_last[i] : i_cur[i];
            end
            r_spike <= o_spike;
            r_done  <= i_calib_done;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.accel_x_out = r_val[0];
    assign o_out.accel_y_out = r_val[1];
    assign o_out.accel_z_out = r_val[2];
    assign o_out.gyro_x_out  = r_val[3];
    assign o_out.gyro_y_out  = r_val[4];
    assign o_out.gyro_z_out  = r_val[5];
    assign o_out.spike_held  = r_spike;
    assign o_out.calib_done  = r_done;

endmodule

`default_nettype wire

// ----- design/imu_offset_spike_filter.sv -----
// imu_offset_spike_filter: top level - six axis lanes, merge stage, sequencer
// and configuration registers; depends on iosf_pkg, iosf_if, iosf_lane, iosf_merge
//
// usage
//   i_in   : one word = req_type plus six raw signed 16-bit axes (accel xyz, gyro xyz)
//   o_out  : one word per input word, six corrected 17-bit axes, spike_held, calib_done
//   i_cfg  : register writes (index 0 accel threshold, 1 gyro threshold,
//            2 calibration count, 3 one g), always ready, write only while idle
//   path: an accepted input word passes capture, correct, compare and merge, and the
//            result word is then held in the output register
//   acceptance: a new word is taken only once the sequencer is back in idle; a
//            calibration word that completes the average also runs the 32 steps of
//            the per-lane bit-serial divider and then loads the offsets before idle
//   stall: the output register holds a finished word while the receiver stalls;
//            the next word is still accepted and worked up to the merge step, where
//            it waits until the output register frees
//   reset: synchronous, active low; offsets, last sample and sums clear, the
//            first-sample flag sets and registers return to their defaults
//   ready on i_in is high only while the sequencer is idle
`default_nettype none

module imu_offset_spike_filter (
    input  wire        i_clk,
    input  wire        i_rst_n,
    iosf_in_if.sink    i_in,
    iosf_out_if.source o_out,
    iosf_cfg_if.sink   i_cfg
);

    localparam int DivCntW = $clog2(iosf_pkg::DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR,
        S_CMP,
        S_MERGE,
        S_DIV,
        S_APPLY
    } t_state;

    t_state                           r_state;
    logic                             r_first_pending;
    logic [iosf_pkg::CNT_W-1:0]       r_seen;
    logic [DivCntW-1:0]               r_div_cnt;
    logic                             r_req_type;

    // configuration registers
    logic [iosf_pkg::VAL_W-1:0]       r_accel_th;
    logic [iosf_pkg::VAL_W-1:0]       r_gyro_th;
    logic [iosf_pkg::CNT_W-1:0]       r_calib_cnt;
    logic [iosf_pkg::ONE_G_W-1:0]     r_one_g;

    iosf_pkg::t_lane_ctrl             w_ctrl;
    logic signed [iosf_pkg::RAW_W-1:0] w_raw [iosf_pkg::AXES];
    logic [iosf_pkg::AXES-1:0]        w_over;
    iosf_pkg::t_s17                   w_cur  [iosf_pkg::AXES];
    iosf_pkg::t_s17                   w_last [iosf_pkg::AXES];
    logic                             w_spike;
    logic                             w_free;
    logic                             w_accept;
    logic                             w_commit;
    logic                             w_done;
    logic [iosf_pkg::CNT_W-1:0]       w_eff_cnt;
    logic [iosf_pkg::CNT_W:0]         w_seen_inc;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_commit    = (r_state == S_MERGE) && w_free;

    // a zero count behaves as one
    assign w_eff_cnt  = (r_calib_cnt == '0) ? iosf_pkg::CNT_W'(1) : r_calib_cnt;
    assign w_seen_inc = {1'b0, r_seen} + (iosf_pkg::CNT_W+1)'(1);
    assign w_done     = r_req_type && (w_seen_inc >= {1'b0, w_eff_cnt});

    always_comb begin
        w_ctrl.capture   = w_accept;
        w_ctrl.calc_cur  = (r_state == S_CUR);
        w_ctrl.calc_cmp  = (r_state == S_CMP);
        w_ctrl.upd_last  = w_commit && !w_spike;
        w_ctrl.accum     = w_commit && r_req_type;
        w_ctrl.div_load  = w_commit && w_done;
        w_ctrl.div_step  = (r_state == S_DIV);
        w_ctrl.div_apply = (r_state == S_APPLY);
    end

    assign w_raw[0] = i_in.raw_accel_x;
    assign w_raw[1] = i_in.raw_accel_y;
    assign w_raw[2] = i_in.raw_accel_z;
    assign w_raw[3] = i_in.raw_gyro_x;
    assign w_raw[4] = i_in.raw_gyro_y;
    assign w_raw[5] = i_in.raw_gyro_z;

    // one lane per axis; accel lanes use the accel threshold, the z lane's offset has one g taken off
    for (genvar g = 0; g < iosf_pkg::AXES; g++) begin : g_lane
        iosf_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_raw     (w_raw[g]),
            .i_thresh  ((g < iosf_pkg::ACCEL_LANES) ? r_accel_th : r_gyro_th),
            .i_div_cnt (w_eff_cnt),
            .i_one_g   ((g == iosf_pkg::Z_LANE) ? r_one_g : '0),
            .o_over    (w_over[g]),
            .o_cur     (w_cur[g]),
            .o_last    (w_last[g])
        );
    end

    iosf_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_commit),
        .i_first_pending (r_first_pending),
        .i_calib_done    (w_done),
        .i_over          (w_over),
        .i_cur           (w_cur),
        .i_last          (w_last),
        .o_spike         (w_spike),
        .o_free          (w_free),
        .o_out           (o_out)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_first_pending <= 1'b1;
            r_seen          <= '0;
            r_div_cnt       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CUR;
                    end
                end
                S_CUR: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    // wait here while the output register still holds a word the receiver has not taken
                    if (w_free) begin
                        if (r_req_type) begin
                            r_seen <= w_done ? '0 : w_seen_inc[iosf_pkg::CNT_W-1:0];
                        end
                        if (w_done) begin
                            // new offsets restart the spike comparison
                            r_first_pending <= 1'b1;
                            r_div_cnt       <= '0;
                            r_state         <= S_DIV;
                        end else begin
                            if (!w_spike) begin
                                r_first_pending <= 1'b0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + DivCntW'(1);
                    if (r_div_cnt == DivCntW'(iosf_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type <= i_in.req_type;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_th  <= iosf_pkg::VAL_W'(4177);
            r_gyro_th   <= iosf_pkg::VAL_W'(8192);
            r_calib_cnt <= iosf_pkg::CNT_W'(1024);
            r_one_g     <= iosf_pkg::ONE_G_W'(2048);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (iosf_pkg::t_cfg_idx'(i_cfg.index))
                iosf_pkg::CFG_ACCEL_TH:  r_accel_th  <= i_cfg.data;
                iosf_pkg::CFG_GYRO_TH:   r_gyro_th   <= i_cfg.data;
                iosf_pkg::CFG_CALIB_CNT: r_calib_cnt <= i_cfg.data[iosf_pkg::CNT_W-1:0];
                iosf_pkg::CFG_ONE_G:     r_one_g     <= i_cfg.data[iosf_pkg::ONE_G_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/iosf_checker.sv -----
// iosf_checker: port-level checks of imu_offset_spike_filter, bound to the top
// depends on iosf_pkg
`default_nettype none

module iosf_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_valid,
    input wire                              i_in_ready,
    input wire                              i_out_valid,
    input wire                              i_out_ready,
    input wire logic [iosf_pkg::VAL_W-1:0]  i_out_ax,
    input wire                              i_out_spike,
    input wire                              i_out_done
);

    logic       r_after_done;
    logic [2:0] r_open;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_done <= 1'b0;
            r_open       <= '0;
        end else begin
            if (w_out_acc) begin
                r_after_done <= i_out_done;
            end
            r_open <= r_open + {2'b00, w_in_acc} - {2'b00, w_out_acc};
        end
    end

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_ax)
            && $stable(i_out_spike) && $stable(i_out_done))
        else $error("result word changed while stalled");

    // one word at a time: ready drops right after an accept
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready)
        else $error("input accepted while previous word in work");

    // a result needs an input word that has not yet been answered
    a_out_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_open != 3'd0)
        else $error("result word without input word");

    // new offsets restart the filter, so the next word cannot be a held spike
    a_no_spike_after_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && r_after_done |-> !i_out_spike)
        else $error("spike held right after calibration");

endmodule

bind imu_offset_spike_filter iosf_checker u_iosf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_ax    (o_out.accel_x_out),
    .i_out_spike (o_out.spike_held),
    .i_out_done  (o_out.calib_done)
);

`default_nettype wire

// ----- dv/imu_offset_spike_filter_tb.sv -----
// imu_offset_spike_filter_tb: self-checking bench for the imu offset/spike filter
// directed table then random phases, each result word checked against a table value or a built-in predictor
// depends on iosf_pkg, iosf_if and imu_offset_spike_filter
`timescale 1ns / 1ps

module imu_offset_spike_filter_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    // divider of a finishing calibration word can outlast its result word
    localparam int DIVIDE_GAP   = 40;
    localparam int MAX_GAP      = 20;
    localparam int STALL_CYCLES = 80;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 72;
    localparam int TIMEOUT_NS   = 3_000_000;

    localparam logic REQ_MEASURE = 1'b0;
    localparam logic REQ_CALIB   = 1'b1;

    typedef struct packed {
        logic                                         req_type;
        logic [iosf_pkg::AXES-1:0][iosf_pkg::RAW_W-1:0] raw;
    } t_sample;

    typedef struct packed {
        logic [iosf_pkg::AXES-1:0][iosf_pkg::VAL_W-1:0] axis;
        logic                                         spike_held;
        logic                                         calib_done;
    } t_result;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        iosf_pkg::t_cfg_idx               idx;
        logic [iosf_pkg::CFG_DAT_W-1:0]   data;
        t_sample                          smp;
        logic                             typed;
        t_result                          want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iosf_in_if  in_if ();
    iosf_out_if out_if ();
    iosf_cfg_if cfg_if ();

    imu_offset_spike_filter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // predictor state, mirrors the block after reset
    longint held [iosf_pkg::AXES]     = '{default: 0};
    longint bias [iosf_pkg::AXES]     = '{default: 0};
    longint bias_sum [iosf_pkg::AXES] = '{default: 0};
    longint cal_seen        = 0;
    bit     first_open      = 1'b1;
    longint accel_lim       = 4177;
    longint gyro_lim        = 8192;
    longint cal_target      = 1024;
    longint g_lsb           = 2048;

    t_result corrected_q [$];
    t_row    stim_table [$];
    int      walk [iosf_pkg::AXES] = '{default: 0};
    int      mismatches  = 0;
    int      tx_idle_pct = 27;
    int      rx_idle_pct = 64;
    int      hold_req_cnt = 0;
    int      hold_seen    = 0;
    int      stall_left   = 0;
    string   axis_name [iosf_pkg::AXES] = '{"accel_x", "accel_y", "accel_z",
                                            "gyro_x", "gyro_y", "gyro_z"};

    function automatic longint clamp17(longint v);
        if (v < -65536) return -65536;
        if (v > 65535) return 65535;
        return v;
    endfunction

    function automatic int clamp16(int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    // offset correction, spike hold and calibration for one accepted word
    function automatic t_result filter_word(t_sample s);
        t_result r;
        longint  raw [iosf_pkg::AXES];
        longint  cur [iosf_pkg::AXES];
        longint  step;
        longint  cnt;
        logic    spike;
        spike = 1'b0;
        for (int i = 0; i < iosf_pkg::AXES; i++) begin
            raw[i] = longint'($signed(s.raw[i]));
            cur[i] = clamp17(raw[i] - bias[i]);
        end
        if (!first_open) begin
            for (int i = 0; i < iosf_pkg::AXES; i++) begin
                step = cur[i] - held[i];
                if (step < 0) step = -step;
                if (step > ((i < iosf_pkg::ACCEL_LANES) ? accel_lim : gyro_lim)) spike = 1'b1;
            end
        end
        // a held word repeats the last accepted sample untouched
        for (int i = 0; i < iosf_pkg::AXES; i++) begin
            if (!spike) held[i] = cur[i];
            r.axis[i] = held[i][iosf_pkg::VAL_W-1:0];
        end
        if (!spike) first_open = 1'b0;
        r.spike_held = spike;
        r.calib_done = 1'b0;
        if (s.req_type == REQ_CALIB) begin
            // zero count behaves as one
            cnt = (cal_target == 0) ? 1 : cal_target;
            for (int i = 0; i < iosf_pkg::AXES; i++) bias_sum[i] += raw[i];
            cal_seen = (cal_seen + 1) & 16'hFFFF;
            if (cal_seen >= cnt) begin
                for (int i = 0; i < iosf_pkg::AXES; i++) begin
                    bias[i] = bias_sum[i] / cnt;
                    if (i == iosf_pkg::Z_LANE) bias[i] -= g_lsb;
                    bias[i] = clamp17(bias[i]);
                    bias_sum[i] = 0;
                end
                cal_seen = 0;
                first_open = 1'b1;
                r.calib_done = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_sample pack_sample(logic req, int ax, int ay, int az,
                                            int gx, int gy, int gz);
        t_sample s;
        s.req_type = req;
        s.raw[0] = ax[iosf_pkg::RAW_W-1:0];
        s.raw[1] = ay[iosf_pkg::RAW_W-1:0];
        s.raw[2] = az[iosf_pkg::RAW_W-1:0];
        s.raw[3] = gx[iosf_pkg::RAW_W-1:0];
        s.raw[4] = gy[iosf_pkg::RAW_W-1:0];
        s.raw[5] = gz[iosf_pkg::RAW_W-1:0];
        return s;
    endfunction

    function automatic t_result pack_result(int ax, int ay, int az, int gx, int gy,
                                            int gz, logic spike, logic done);
        t_result r;
        r.axis[0] = ax[iosf_pkg::VAL_W-1:0];
        r.axis[1] = ay[iosf_pkg::VAL_W-1:0];
        r.axis[2] = az[iosf_pkg::VAL_W-1:0];
        r.axis[3] = gx[iosf_pkg::VAL_W-1:0];
        r.axis[4] = gy[iosf_pkg::VAL_W-1:0];
        r.axis[5] = gz[iosf_pkg::VAL_W-1:0];
        r.spike_held = spike;
        r.calib_done = done;
        return r;
    endfunction

    function automatic t_row item_row(t_sample s, logic typed = 1'b0, t_result want = '0);
        t_row r;
        r = '0;
        r.kind  = ROW_ITEM;
        r.smp   = s;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic t_row reg_row(iosf_pkg::t_cfg_idx idx, int data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = iosf_pkg::CFG_DAT_W'(data);
        return r;
    endfunction

    // random walk with small steps, some jumps past the limit, some fully random words and corner values
    function automatic t_sample next_sample();
        t_sample s;
        int      pick;
        int      lim;
        int      span;
        int      v;
        pick = $urandom_range(0, 99);
        s.req_type = ($urandom_range(0, 99) < 20) ? REQ_CALIB : REQ_MEASURE;
        for (int i = 0; i < iosf_pkg::AXES; i++) begin
            lim  = int'((i < iosf_pkg::ACCEL_LANES) ? accel_lim : gyro_lim);
            span = (lim > 3000) ? 3000 : lim;
            if (pick < 12) begin
                v = int'($urandom_range(0, 65535)) - 32768;
                walk[i] = v;
            end else if (pick < 20) begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
                walk[i] = v;
            end else if (pick < 30) begin
                // jump beyond the limit, walk stays put so the next word lands near
                v = int'($urandom_range(1, 4000)) + lim;
                v = clamp16(($urandom_range(0, 1) != 0) ? walk[i] + v : walk[i] - v);
            end else begin
                v = clamp16(walk[i] + int'($urandom_range(0, 2 * span)) - span);
                walk[i] = v;
            end
            s.raw[i] = v[iosf_pkg::RAW_W-1:0];
        end
        return s;
    endfunction

    // offer one word after a random gap, return at the accepting edge
    task automatic send_sample(input t_sample s);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.req_type    <= s.req_type;
        in_if.raw_accel_x <= s.raw[0];
        in_if.raw_accel_y <= s.raw[1];
        in_if.raw_accel_z <= s.raw[2];
        in_if.raw_gyro_x  <= s.raw[3];
        in_if.raw_gyro_y  <= s.raw[4];
        in_if.raw_gyro_z  <= s.raw[5];
        in_if.valid       <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // stop offering and wait until every predicted word has come back
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (corrected_q.size() != 0);
    endtask

    // block idle: nothing pending and any divider run finished
    task automatic settle();
        drain();
        repeat (DIVIDE_GAP) @(posedge i_clk);
    endtask

    // leaves valid high, caller lowers it after the last write of a batch
    task automatic write_reg(input iosf_pkg::t_cfg_idx idx,
                             input logic [iosf_pkg::CFG_DAT_W-1:0] data);
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            iosf_pkg::CFG_ACCEL_TH:  accel_lim  = data;
            iosf_pkg::CFG_GYRO_TH:   gyro_lim   = data;
            iosf_pkg::CFG_CALIB_CNT: cal_target = data[iosf_pkg::CNT_W-1:0];
            iosf_pkg::CFG_ONE_G:     g_lsb      = data[iosf_pkg::ONE_G_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input int a_th, input int g_th, input int cnt, input int one_g);
        settle();
        write_reg(iosf_pkg::CFG_ACCEL_TH, iosf_pkg::CFG_DAT_W'(a_th));
        write_reg(iosf_pkg::CFG_GYRO_TH, iosf_pkg::CFG_DAT_W'(g_th));
        write_reg(iosf_pkg::CFG_CALIB_CNT, iosf_pkg::CFG_DAT_W'(cnt));
        write_reg(iosf_pkg::CFG_ONE_G, iosf_pkg::CFG_DAT_W'(one_g));
        cfg_if.valid <= 1'b0;
    endtask

    // result side: random ready, plus one long hold-off on request
    always @(posedge i_clk) begin : result_ready
        if (hold_seen != hold_req_cnt) begin
            hold_seen  = hold_req_cnt;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.axis[0]    = out_if.accel_x_out;
            got.axis[1]    = out_if.accel_y_out;
            got.axis[2]    = out_if.accel_z_out;
            got.axis[3]    = out_if.gyro_x_out;
            got.axis[4]    = out_if.gyro_y_out;
            got.axis[5]    = out_if.gyro_z_out;
            got.spike_held = out_if.spike_held;
            got.calib_done = out_if.calib_done;
            if (corrected_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, got);
                mismatches++;
            end else begin
                want = corrected_q.pop_front();
                for (int i = 0; i < iosf_pkg::AXES; i++) begin
                    if (got.axis[i] !== want.axis[i]) begin
                        $display("%0t: %s expected %0d, got %0d", $time, axis_name[i],
                                 $signed(want.axis[i]), $signed(got.axis[i]));
                        mismatches++;
                    end
                end
                if ({got.spike_held, got.calib_done} !== {want.spike_held, want.calib_done})
                begin
                    $display("%0t: spike_held/calib_done expected %b/%b, got %b/%b", $time,
                             want.spike_held, want.calib_done, got.spike_held, got.calib_done);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        t_row    row;
        t_sample smp;
        t_result pred;
        logic    cfg_open;

        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.req_type     <= REQ_MEASURE;
        in_if.raw_accel_x  <= '0;
        in_if.raw_accel_y  <= '0;
        in_if.raw_accel_z  <= '0;
        in_if.raw_gyro_x   <= '0;
        in_if.raw_gyro_y   <= '0;
        in_if.raw_gyro_z   <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= iosf_pkg::CFG_ACCEL_TH;
        cfg_if.data        <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds: first word taken as is, then steps at and past each limit
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, 0, 0, 0, 0, 0, 0), 1'b1,
                                      pack_result(0, 0, 0, 0, 0, 0, 1'b0, 1'b0)));
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, 4177, 0, 0, 0, 0, 0), 1'b1,
                                      pack_result(4177, 0, 0, 0, 0, 0, 1'b0, 1'b0)));
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, 8355, 0, 0, 0, 0, 0), 1'b1,
                                      pack_result(4177, 0, 0, 0, 0, 0, 1'b1, 1'b0)));
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, 4177, 0, 0, 0, 0, 8193), 1'b1,
                                      pack_result(4177, 0, 0, 0, 0, 0, 1'b1, 1'b0)));
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, 4177, 0, 0, 0, 0, 8192), 1'b1,
                                      pack_result(4177, 0, 0, 0, 0, 8192, 1'b0, 1'b0)));
        // widest thresholds, single-word calibration, largest one g
        stim_table.push_back(reg_row(iosf_pkg::CFG_ACCEL_TH, 131071));
        stim_table.push_back(reg_row(iosf_pkg::CFG_GYRO_TH, 131071));
        stim_table.push_back(reg_row(iosf_pkg::CFG_CALIB_CNT, 1));
        stim_table.push_back(reg_row(iosf_pkg::CFG_ONE_G, 32767));
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, 32767, 32767, 32767,
                                                  32767, 32767, 32767), 1'b1,
                                      pack_result(32767, 32767, 32767, 32767, 32767, 32767,
                                                  1'b0, 1'b0)));
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, -32768, -32768, -32768,
                                                  -32768, -32768, -32768), 1'b1,
                                      pack_result(-32768, -32768, -32768, -32768, -32768,
                                                  -32768, 1'b0, 1'b0)));
        // calibration word still uses the old offsets
        stim_table.push_back(item_row(pack_sample(REQ_CALIB, 32767, -32768, -32768,
                                                  -1, 1, 0), 1'b1,
                                      pack_result(32767, -32768, -32768, -1, 1, 0,
                                                  1'b0, 1'b1)));
        // new offsets apply, z correction saturates high
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, -32768, 32767, 32767,
                                                  0, 0, 0), 1'b1,
                                      pack_result(-65535, 65535, 65535, 1, -1, 0,
                                                  1'b0, 1'b0)));
        // zero thresholds: only an identical word passes
        stim_table.push_back(reg_row(iosf_pkg::CFG_ACCEL_TH, 0));
        stim_table.push_back(reg_row(iosf_pkg::CFG_GYRO_TH, 0));
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, -32768, 32767, 32767,
                                                  0, 0, 0)));
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, -32768, 32767, 32767,
                                                  1, 0, 0)));
        // zero count acts as one
        stim_table.push_back(reg_row(iosf_pkg::CFG_CALIB_CNT, 0));
        stim_table.push_back(reg_row(iosf_pkg::CFG_ONE_G, 0));
        stim_table.push_back(item_row(pack_sample(REQ_CALIB, 0, 0, 0, 0, 0, 0)));
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, 100, -100, 2048, 5, -5, 0)));
        // largest count, then lowered below what was already summed
        stim_table.push_back(reg_row(iosf_pkg::CFG_ACCEL_TH, 4177));
        stim_table.push_back(reg_row(iosf_pkg::CFG_GYRO_TH, 8192));
        stim_table.push_back(reg_row(iosf_pkg::CFG_CALIB_CNT, 65535));
        stim_table.push_back(reg_row(iosf_pkg::CFG_ONE_G, 2048));
        stim_table.push_back(item_row(pack_sample(REQ_CALIB, -3, 7, 2000, -1, 0, 32767)));
        stim_table.push_back(item_row(pack_sample(REQ_CALIB, -4, 8, 2100, -2, 1, -32768)));
        stim_table.push_back(item_row(pack_sample(REQ_CALIB, -2, 9, 2050, -1, 1, 5)));
        stim_table.push_back(reg_row(iosf_pkg::CFG_CALIB_CNT, 2));
        // negative odd sums check truncation toward zero
        stim_table.push_back(item_row(pack_sample(REQ_CALIB, 0, -1, 2047, 1, -1, 3)));
        stim_table.push_back(item_row(pack_sample(REQ_MEASURE, 0, 0, 2048, 0, 0, 0)));

        cfg_open = 1'b0;
        foreach (stim_table[k]) begin
            row = stim_table[k];
            if (row.kind == ROW_CFG) begin
                if (!cfg_open) settle();
                cfg_open = 1'b1;
                write_reg(row.idx, row.data);
            end else begin
                if (cfg_open) cfg_if.valid <= 1'b0;
                cfg_open = 1'b0;
                send_sample(row.smp);
                pred = filter_word(row.smp);
                corrected_q.push_back(row.typed ? row.want : pred);
            end
        end
        if (cfg_open) cfg_if.valid <= 1'b0;

        // random phases: sender-light, then receiver-light, then no idling
        for (int p = 0; p < PHASES; p++) begin
            if (p < 2) begin
                tx_idle_pct = 27;
                rx_idle_pct = 64;
            end else if (p < 4) begin
                tx_idle_pct = 64;
                rx_idle_pct = 27;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p)
                0: program_regs(4177, 8192, 4, 2048);
                1: program_regs(0, 131071, 3, 32767);
                2: program_regs(131071, 0, 1, 0);
                5: program_regs(300, 600, 5, 2048);
                default: program_regs(int'($urandom_range(0, 20000)),
                                      int'($urandom_range(0, 40000)),
                                      int'($urandom_range(1, 8)),
                                      int'($urandom_range(0, 32767)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while words keep coming, fills the pipe
                if (p == 4 && n == 10) hold_req_cnt <= hold_req_cnt + 1;
                // sender pause until the pipe is empty
                if (p == 2 && n == 36) drain();
                smp = next_sample();
                send_sample(smp);
                corrected_q.push_back(filter_word(smp));
            end
        end

        drain();
        repeat (DIVIDE_GAP) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/iosf_pkg.sv
design/iosf_if.sv
design/iosf_lane.sv
design/iosf_merge.sv
design/imu_offset_spike_filter.sv
design/iosf_checker.sv
dv/imu_offset_spike_filter_tb.sv
